// File: hw/rtl/kms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_pkg
// Shared widths, codes, mixer constants and controller command/status types
// for the k-mer MinHash sketch core.
// ----------------------------------------------------------------------------
package kms_pkg;

	// payload widths
	localparam int OPERATION_W    = 2;
	localparam int BASE_CHAR_W    = 8;
	localparam int BUCKET_INDEX_W = 12;
	localparam int MINIMUM_W      = 63;
	localparam int FILLED_CNT_W   = 13;
	localparam int HASH_W         = 64;
	localparam int HALF_W         = 32;

	// configuration registers
	localparam int KMER_LENGTH_W  = 5;
	localparam int BUCKET_BITS_W  = 4;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BUCKET_BITS = 2'd1;

	localparam logic [KMER_LENGTH_W-1:0] KMER_LENGTH_RST = 5'd31;
	localparam logic [BUCKET_BITS_W-1:0] BUCKET_BITS_RST = 4'd10;

	localparam int DEF_MAX_BUCKET_BITS = 12;
	localparam int DEF_MAX_KMER_LENGTH = 31;

	// operation codes
	localparam logic [OPERATION_W-1:0] OP_START = 2'd0;
	localparam logic [OPERATION_W-1:0] OP_BASE  = 2'd1;
	localparam logic [OPERATION_W-1:0] OP_READ  = 2'd2;

	// mixer multipliers
	localparam logic [HASH_W-1:0] MIX_A = 64'hD6E8FEB86659FD93;
	localparam logic [HASH_W-1:0] MIX_B = 64'hCFEE444D8B59A89B;

	// ascii bases
	localparam logic [BASE_CHAR_W-1:0] CHAR_A = 8'h41;
	localparam logic [BASE_CHAR_W-1:0] CHAR_C = 8'h43;
	localparam logic [BASE_CHAR_W-1:0] CHAR_G = 8'h47;
	localparam logic [BASE_CHAR_W-1:0] CHAR_T = 8'h54;

	typedef struct packed {
		logic clear_seq;  // start: drop k-mers and filled count
		logic clr_wr;     // clearing pass write
		logic base_take;  // roll a base into the k-mers
		logic rd_ext;     // read bucket chosen by the input word
		logic load_a;     // load canonical k-mer, mixer a
		logic load_b;     // load canonical k-mer, mixer b
		logic mul0;
		logic mul1;
		logic mul2;
		logic fold;
		logic rd_hash;    // read bucket chosen by hash b
		logic upd;        // min update of that bucket
		logic out_load;
	} kms_cmd_t;

	typedef struct packed {
		logic kmer_ready;  // next base completes a k-mer
		logic clr_last;
		logic round_last;
		logic mix_b;
		logic out_free;
	} kms_status_t;

	function automatic logic [1:0] fwd_code(input logic [BASE_CHAR_W-1:0] ch);
		logic [1:0] c;
		case (ch)
			CHAR_C: c = 2'd1;
			CHAR_G: c = 2'd2;
			CHAR_T: c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] rc_code(input logic [BASE_CHAR_W-1:0] ch);
		logic [1:0] c;
		case (ch)
			CHAR_A: c = 2'd3;
			CHAR_C: c = 2'd2;
			CHAR_G: c = 2'd1;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/kms_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kms_cfg_if import kms_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/kms_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_in_if
// Input word channel: operation, base character and bucket index.
// ----------------------------------------------------------------------------
interface kms_in_if import kms_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [OPERATION_W-1:0]    operation;
	logic [BASE_CHAR_W-1:0]    base_char;
	logic [BUCKET_INDEX_W-1:0] bucket_index;

	modport source (output valid, output operation, output base_char, output bucket_index,
		input ready);
	modport sink (input valid, input operation, input base_char, input bucket_index,
		output ready);
endinterface

// File: hw/rtl/kms_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_out_if
// Result word channel: bucket minimum, filled flag and filled bucket count.
// ----------------------------------------------------------------------------
interface kms_out_if import kms_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [MINIMUM_W-1:0]    bucket_minimum;
	logic                    bucket_filled;
	logic [FILLED_CNT_W-1:0] filled_buckets;

	modport source (output valid, output bucket_minimum, output bucket_filled,
		output filled_buckets, input ready);
	modport sink (input valid, input bucket_minimum, input bucket_filled,
		input filled_buckets, output ready);
endinterface

// File: hw/rtl/kmer_minhash_sketch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_minhash_sketch_core
// One-permutation MinHash sketch of canonical DNA k-mers with per-bucket
// minimum tracking, start/clear and bucket read operations.
// ----------------------------------------------------------------------------
//  channel  direction  payload                                          handshake
//  cfg      in         index, data                                      valid/ready
//  item     in         operation, base_char, bucket_index               valid/ready
//  result   out        bucket_minimum, bucket_filled, filled_buckets    valid/ready
//
//  a base that does not complete a k-mer only rolls the k-mers; one that does
//  runs two mixers (4 steps per round on the single 32x32 multiplier), then a
//  bucket read-modify-write; a read fetches the bucket, then waits out any result stall
//  reset and every start run a clearing pass over every entry of the bucket
//  memory; item.ready stays low meanwhile, cfg is always ready
//  the result register frees the input side once loaded
// ----------------------------------------------------------------------------
module kmer_minhash_sketch_core import kms_pkg::*; #(
	parameter int MAX_BUCKET_BITS = DEF_MAX_BUCKET_BITS,
	parameter int MAX_KMER_LENGTH = DEF_MAX_KMER_LENGTH
) (
	input  logic      clk,
	input  logic      arst_n,
	kms_cfg_if.sink   cfg,
	kms_in_if.sink    item,
	kms_out_if.source result
);

	kms_cmd_t    cmd;
	kms_status_t status;

	assign cfg.ready = 1'b1;

	kms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.operation),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	kms_datapath #(
		.MAX_BUCKET_BITS (MAX_BUCKET_BITS),
		.MAX_KMER_LENGTH (MAX_KMER_LENGTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.base_char    (item.base_char),
		.bucket_index (item.bucket_index),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_minimum  (result.bucket_minimum),
		.out_filled   (result.bucket_filled),
		.out_count    (result.filled_buckets)
	);

endmodule

// File: hw/rtl/kms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_ctrl
// Sequencer: clearing pass, the two-mixer hash schedule on the shared
// multiplier, bucket read-modify-write and bucket reads.
// ----------------------------------------------------------------------------
module kms_ctrl import kms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [OPERATION_W-1:0] in_op,
	output logic                   in_ready,
	input  kms_status_t            status,
	output kms_cmd_t               cmd
);

	typedef enum logic [10:0] {
		ST_CLEAR    = 11'b000_0000_0001,
		ST_IDLE     = 11'b000_0000_0010,
		ST_LOAD_A   = 11'b000_0000_0100,
		ST_LOAD_B   = 11'b000_0000_1000,
		ST_MUL0     = 11'b000_0001_0000,
		ST_MUL1     = 11'b000_0010_0000,
		ST_MUL2     = 11'b000_0100_0000,
		ST_FOLD     = 11'b000_1000_0000,
		ST_HASH_RD  = 11'b001_0000_0000,
		ST_HASH_UPD = 11'b010_0000_0000,
		ST_READ_OUT = 11'b100_0000_0000
	} kms_state_t;

	kms_state_t state_q;
	kms_state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_START: begin
							cmd.clear_seq = 1'b1;
							state_d       = ST_CLEAR;
						end
						OP_BASE: begin
							cmd.base_take = 1'b1;
							if (status.kmer_ready) begin
								state_d = ST_LOAD_A;
							end
						end
						OP_READ: begin
							cmd.rd_ext = 1'b1;
							state_d    = ST_READ_OUT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LOAD_A: begin
				cmd.load_a = 1'b1;
				state_d    = ST_MUL0;
			end
			ST_LOAD_B: begin
				cmd.load_b = 1'b1;
				state_d    = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!status.round_last) begin
					state_d = ST_MUL0;
				end else if (!status.mix_b) begin
					state_d = ST_LOAD_B;
				end else begin
					state_d = ST_HASH_RD;
				end
			end
			ST_HASH_RD: begin
				cmd.rd_hash = 1'b1;
				state_d     = ST_HASH_UPD;
			end
			ST_HASH_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/kms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_datapath
// Configuration registers, rolling k-mers, shared 32x32 mixer multiplier,
// bucket memory with clearing counter, filled count and result register.
// ----------------------------------------------------------------------------
module kms_datapath import kms_pkg::*; #(
	parameter int MAX_BUCKET_BITS = DEF_MAX_BUCKET_BITS,
	parameter int MAX_KMER_LENGTH = DEF_MAX_KMER_LENGTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kms_cmd_t                  cmd,
	output kms_status_t               status,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [BASE_CHAR_W-1:0]    base_char,
	input  logic [BUCKET_INDEX_W-1:0] bucket_index,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [MINIMUM_W-1:0]      out_minimum,
	output logic                      out_filled,
	output logic [FILLED_CNT_W-1:0]   out_count
);

	localparam int KW    = 2 * MAX_KMER_LENGTH;
	localparam int AW    = MAX_BUCKET_BITS;
	localparam int DEPTH = 1 << MAX_BUCKET_BITS;
	localparam int LFW   = $clog2(MAX_BUCKET_BITS + 1);
	localparam int CW    = (LFW > BUCKET_BITS_W) ? LFW : BUCKET_BITS_W;
	localparam int SW    = $clog2(KW);
	localparam int SHW   = (SW > 0) ? SW : 1;
	localparam int MW    = MINIMUM_W + 1;

	// configuration
	logic [KMER_LENGTH_W-1:0] kmer_len_q;
	logic [BUCKET_BITS_W-1:0] bucket_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q    <= KMER_LENGTH_RST;
			bucket_bits_q <= BUCKET_BITS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_KMER_LENGTH) begin
				kmer_len_q <= cfg_data[KMER_LENGTH_W-1:0];
			end
			if (cfg_index == REG_BUCKET_BITS) begin
				bucket_bits_q <= cfg_data[BUCKET_BITS_W-1:0];
			end
		end
	end

	// clamped k and bucket bits
	logic [KMER_LENGTH_W-1:0] eff_k;
	logic [CW-1:0]            lf_raw;
	logic [LFW-1:0]           eff_lf;

	always_comb begin
		if (kmer_len_q == '0) begin
			eff_k = KMER_LENGTH_W'(1);
		end else if (kmer_len_q > KMER_LENGTH_W'(MAX_KMER_LENGTH)) begin
			eff_k = KMER_LENGTH_W'(MAX_KMER_LENGTH);
		end else begin
			eff_k = kmer_len_q;
		end
	end

	always_comb begin
		lf_raw = CW'(bucket_bits_q);
		if (lf_raw == '0) begin
			eff_lf = LFW'(1);
		end else if (lf_raw > CW'(MAX_BUCKET_BITS)) begin
			eff_lf = LFW'(MAX_BUCKET_BITS);
		end else begin
			eff_lf = LFW'(lf_raw);
		end
	end

	// rolling k-mers
	logic [KW-1:0]            fwd_q;
	logic [KW-1:0]            rev_q;
	logic [KMER_LENGTH_W-1:0] bases_q;
	logic [KW-1:0]            kmer_mask;
	logic [KMER_LENGTH_W:0]   two_k;
	logic [KMER_LENGTH_W:0]   top_pos;
	logic [KW-1:0]            fwd_shl;
	logic [KW-1:0]            fwd_d;
	logic [KW-1:0]            rc_top;
	logic [KW-1:0]            rev_d;

	assign two_k   = {eff_k, 1'b0};
	assign top_pos = two_k - (KMER_LENGTH_W + 1)'(2);

	always_comb begin
		for (int i = 0; i < KW; i++) begin
			kmer_mask[i] = ((KMER_LENGTH_W + 1)'(i) < two_k);
		end
	end

	assign fwd_shl = fwd_q << 2;
	assign fwd_d   = (fwd_shl | KW'(fwd_code(base_char))) & kmer_mask;
	assign rc_top  = KW'(rc_code(base_char)) << top_pos[SHW-1:0];
	// a real add: after k shrinks, stale high bits can carry into the new top base
	assign rev_d   = ((rev_q >> 2) + rc_top) & kmer_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= '0;
			rev_q   <= '0;
			bases_q <= '0;
		end else if (cmd.clear_seq) begin
			fwd_q   <= '0;
			rev_q   <= '0;
			bases_q <= '0;
		end else if (cmd.base_take) begin
			fwd_q <= fwd_d;
			rev_q <= rev_d;
			if (bases_q < eff_k) begin
				bases_q <= bases_q + KMER_LENGTH_W'(1);
			end
		end
	end

	assign status.kmer_ready = (bases_q >= (eff_k - KMER_LENGTH_W'(1)));

	// canonical k-mer
	logic [HASH_W-1:0] canon;

	assign canon = HASH_W'((fwd_q < rev_q) ? fwd_q : rev_q);

	// mixer on one shared 32x32 multiplier
	logic [HASH_W-1:0]    x_q;
	logic [HASH_W-1:0]    acc_q;
	logic                 round_q;
	logic                 mix_b_q;
	logic [MINIMUM_W-1:0] ha_q;
	logic [HASH_W-1:0]    mul_c;
	logic [HALF_W-1:0]    mul_x;
	logic [HALF_W-1:0]    mul_m;
	logic [HASH_W-1:0]    prod;
	logic [HASH_W-1:0]    fold_val;

	assign mul_c    = mix_b_q ? MIX_B : MIX_A;
	assign mul_x    = cmd.mul1 ? x_q[HASH_W-1:HALF_W] : x_q[HALF_W-1:0];
	assign mul_m    = cmd.mul2 ? mul_c[HASH_W-1:HALF_W] : mul_c[HALF_W-1:0];
	assign prod     = HASH_W'(mul_x) * HASH_W'(mul_m);
	assign fold_val = acc_q ^ (acc_q >> HALF_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= 1'b0;
			mix_b_q <= 1'b0;
		end else if (cmd.load_a || cmd.load_b) begin
			round_q <= 1'b0;
			mix_b_q <= cmd.load_b;
		end else if (cmd.fold) begin
			round_q <= ~round_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a || cmd.load_b) begin
			x_q <= canon ^ (canon >> HALF_W);
		end else if (cmd.fold) begin
			x_q <= fold_val;
		end
		// low 64 bits of the product: cross terms only touch the upper half
		if (cmd.mul0) begin
			acc_q <= prod;
		end else if (cmd.mul1 || cmd.mul2) begin
			acc_q[HASH_W-1:HALF_W] <= acc_q[HASH_W-1:HALF_W] + prod[HALF_W-1:0];
		end
		if (cmd.fold && round_q && !mix_b_q) begin
			ha_q <= fold_val[MINIMUM_W-1:0];
		end
	end

	assign status.round_last = round_q;
	assign status.mix_b      = mix_b_q;

	// bucket index from the top bits of hash b
	logic [AW-1:0]  hb_top;
	logic [LFW-1:0] idx_shift;
	logic [AW-1:0]  hash_idx;

	assign hb_top    = x_q[HASH_W-1 -: AW];
	assign idx_shift = LFW'(MAX_BUCKET_BITS) - eff_lf;
	assign hash_idx  = hb_top >> idx_shift;

	// bucket memory: {filled, minimum}
	logic [MW-1:0] mem [DEPTH];
	logic [MW-1:0] rdata_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [MW-1:0] wdata;
	logic          rd_en;
	logic          wr_en;
	logic          hit_empty;
	logic          hit_lower;

	assign raddr     = cmd.rd_ext ? AW'(bucket_index) : hash_idx;
	assign rd_en     = cmd.rd_ext | cmd.rd_hash;
	assign hit_empty = ~rdata_q[MW-1];
	assign hit_lower = (ha_q < rdata_q[MINIMUM_W-1:0]);
	assign wr_en     = cmd.clr_wr | (cmd.upd & (hit_empty | hit_lower));
	assign waddr     = cmd.clr_wr ? clr_q : hash_idx;
	assign wdata     = cmd.clr_wr ? '0 : {1'b1, ha_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_seq) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign status.clr_last = &clr_q;

	// filled bucket count
	logic [FILLED_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_seq) begin
			count_q <= '0;
		end else if (cmd.upd && hit_empty) begin
			count_q <= count_q + FILLED_CNT_W'(1);
		end
	end

	// result register
	logic                    out_valid_q;
	logic [MINIMUM_W-1:0]    out_min_q;
	logic                    out_filled_q;
	logic [FILLED_CNT_W-1:0] out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_min_q    <= rdata_q[MW-1] ? rdata_q[MINIMUM_W-1:0] : '0;
			out_filled_q <= rdata_q[MW-1];
			out_count_q  <= count_q;
		end
	end

	assign status.out_free = ~out_valid_q | out_ready;

	assign out_valid   = out_valid_q;
	assign out_minimum = out_min_q;
	assign out_filled  = out_filled_q;
	assign out_count   = out_count_q;

endmodule

// File: tb/kms_sketch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_sketch_checker
// Watches the register, word and result channels of the sketch core, keeps
// its own copy of the rolling k-mers and bucket minima, and compares every
// result word field by field against the oldest outstanding bucket read.
// ----------------------------------------------------------------------------
module kms_sketch_checker import kms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	kms_cfg_if   cfg,
	kms_in_if    item,
	kms_out_if   result,
	output int   errors,
	output int   pending
);

	localparam int STORE_DEPTH = 1 << DEF_MAX_BUCKET_BITS;
	localparam int KMER_BITS   = 2 * DEF_MAX_KMER_LENGTH;

	typedef struct packed {
		logic [MINIMUM_W-1:0]    minimum;
		logic                    filled;
		logic [FILLED_CNT_W-1:0] count;
	} bucket_read_t;

	bucket_read_t reads_due[$];
	bucket_read_t due;
	bucket_read_t fresh;
	int read_slot;

	logic [KMER_LENGTH_W-1:0] kmer_length;
	logic [BUCKET_BITS_W-1:0] bucket_bits;
	logic [KMER_BITS-1:0]     fwd_kmer;
	logic [KMER_BITS-1:0]     rc_kmer;
	logic [KMER_LENGTH_W-1:0] bases_seen;
	logic [MINIMUM_W-1:0]     bucket_min [STORE_DEPTH];
	logic                     bucket_full [STORE_DEPTH];
	logic [FILLED_CNT_W-1:0]  filled_count;

	function automatic logic [HASH_W-1:0] xorshift_mix(input logic [HASH_W-1:0] x,
			input logic [HASH_W-1:0] mul);
		logic [HASH_W-1:0] v;
		v = ((x >> HALF_W) ^ x) * mul;
		v = ((v >> HALF_W) ^ v) * mul;
		return (v >> HALF_W) ^ v;
	endfunction

	// forward code in the upper pair, complement code in the lower pair
	function automatic logic [3:0] base_codes(input logic [BASE_CHAR_W-1:0] ch);
		logic [3:0] c;
		case (ch)
			CHAR_A: c = 4'b00_11;
			CHAR_C: c = 4'b01_10;
			CHAR_G: c = 4'b10_01;
			CHAR_T: c = 4'b11_00;
			default: c = 4'b00_00;
		endcase
		return c;
	endfunction

	task automatic clear_sketch();
		fwd_kmer = '0;
		rc_kmer = '0;
		bases_seen = '0;
		filled_count = '0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			bucket_min[i] = '0;
			bucket_full[i] = 1'b0;
		end
	endtask

	task automatic roll_base(input logic [BASE_CHAR_W-1:0] ch);
		int k;
		int lf;
		int slot;
		logic [3:0] codes;
		logic [HASH_W-1:0] fwd_code, rc_code, mask, fwd_next, rc_next, canon, hash_a, hash_b;
		k = (kmer_length == 0) ? 1 : int'(kmer_length);
		if (k > DEF_MAX_KMER_LENGTH)
			k = DEF_MAX_KMER_LENGTH;
		lf = (bucket_bits == 0) ? 1 : int'(bucket_bits);
		if (lf > DEF_MAX_BUCKET_BITS)
			lf = DEF_MAX_BUCKET_BITS;
		codes = base_codes(ch);
		fwd_code = HASH_W'(codes[3:2]);
		rc_code = HASH_W'(codes[1:0]);
		mask = (64'd1 << (2 * k)) - 64'd1;
		fwd_next = (({2'b00, fwd_kmer} << 2) + fwd_code) & mask;
		rc_next = (({2'b00, rc_kmer} >> 2) + (rc_code << (2 * k - 2))) & mask;
		fwd_kmer = fwd_next[KMER_BITS-1:0];
		rc_kmer = rc_next[KMER_BITS-1:0];
		if (int'(bases_seen) < k)
			bases_seen = bases_seen + KMER_LENGTH_W'(1);
		if (int'(bases_seen) < k)
			return;
		canon = (fwd_next < rc_next) ? fwd_next : rc_next;
		hash_a = xorshift_mix(canon, MIX_A);
		hash_b = xorshift_mix(canon, MIX_B);
		slot = int'(hash_b >> (HASH_W - lf)) & (STORE_DEPTH - 1);
		if (!bucket_full[slot]) begin
			bucket_full[slot] = 1'b1;
			bucket_min[slot] = hash_a[MINIMUM_W-1:0];
			filled_count = filled_count + FILLED_CNT_W'(1);
		end else if (hash_a[MINIMUM_W-1:0] < bucket_min[slot]) begin
			bucket_min[slot] = hash_a[MINIMUM_W-1:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length = KMER_LENGTH_RST;
			bucket_bits = BUCKET_BITS_RST;
			clear_sketch();
			reads_due.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KMER_LENGTH: kmer_length = cfg.data[KMER_LENGTH_W-1:0];
					REG_BUCKET_BITS: bucket_bits = cfg.data[BUCKET_BITS_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				case (item.operation)
					OP_START: clear_sketch();
					OP_BASE: roll_base(item.base_char);
					OP_READ: begin
						read_slot = int'(item.bucket_index) & (STORE_DEPTH - 1);
						// an empty bucket reads back as zero
						fresh.minimum = bucket_full[read_slot] ? bucket_min[read_slot] : '0;
						fresh.filled = bucket_full[read_slot];
						fresh.count = filled_count;
						reads_due = {reads_due, fresh};
					end
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (reads_due.size() == 0) begin
					$error("result word with no bucket read outstanding");
					errors++;
				end else begin
					due = reads_due.pop_front();
					if (result.bucket_minimum !== due.minimum) begin
						$error("bucket_minimum: expected %h, got %h", due.minimum,
							result.bucket_minimum);
						errors++;
					end
					if (result.bucket_filled !== due.filled) begin
						$error("bucket_filled: expected %b, got %b", due.filled,
							result.bucket_filled);
						errors++;
					end
					if (result.filled_buckets !== due.count) begin
						$error("filled_buckets: expected %0d, got %0d", due.count,
							result.filled_buckets);
						errors++;
					end
				end
			end
		end
		pending = reads_due.size();
	end

endmodule

// File: tb/kmer_minhash_sketch_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_minhash_sketch_core_tb
// Streams base, start and bucket read words into the sketch core through a
// series of k-mer length and bucket width settings, with random gaps on the
// word side and random stalls on the result side; the checker beside the
// core predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module kmer_minhash_sketch_core_tb;
	import kms_pkg::*;

	localparam logic [OPERATION_W-1:0] OP_NONE     = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int PHASES          = 9;
	localparam int WORDS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES   = 40;
	localparam int LIMIT_CYCLES    = 1_500_000;

	logic clk = 1'b0;
	logic arst_n;
	int errors;
	int pending;
	int cycle_count;
	int calm_left;
	int span_mask;
	int n_useful, n_bases, n_reads, n_starts, n_ignored, n_settings;

	kms_cfg_if cfg_bus ();
	kms_in_if  word_bus ();
	kms_out_if read_bus ();

	kmer_minhash_sketch_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (word_bus),
		.result (read_bus)
	);

	kms_sketch_checker sketch_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.item    (word_bus),
		.result  (read_bus),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_word(input logic [OPERATION_W-1:0] op,
			input logic [BASE_CHAR_W-1:0] ch, input logic [BUCKET_INDEX_W-1:0] idx);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(20, 80);
			gap = gap_len();
		end
		if (gap > 0) begin
			word_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word_bus.valid <= 1'b1;
		word_bus.operation <= op;
		word_bus.base_char <= ch;
		word_bus.bucket_index <= idx;
		do @(posedge clk); while (!word_bus.ready);
		@(negedge clk);
		case (op)
			OP_START: n_starts++;
			OP_BASE: n_bases++;
			OP_READ: n_reads++;
			default: n_ignored++;
		endcase
		if (op != OP_NONE)
			n_useful++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
	endtask

	// registers change only once the core has drained and finished any clear pass
	task automatic program_regs(input logic [CFG_DATA_W-1:0] klen,
			input logic [CFG_DATA_W-1:0] bits, input bit both, input bit spare);
		int lf;
		word_bus.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		while (!word_bus.ready) @(negedge clk);
		write_reg(REG_KMER_LENGTH, klen);
		if (both) begin
			write_reg(REG_BUCKET_BITS, bits);
			lf = int'(bits[BUCKET_BITS_W-1:0]);
			if (lf == 0)
				lf = 1;
			if (lf > DEF_MAX_BUCKET_BITS)
				lf = DEF_MAX_BUCKET_BITS;
			span_mask = (1 << lf) - 1;
		end
		if (spare) begin
			write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 31)));
			write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 31)));
		end
		cfg_bus.valid <= 1'b0;
		n_settings++;
	endtask

	task automatic random_word();
		int pick;
		logic [OPERATION_W-1:0] op;
		logic [BASE_CHAR_W-1:0] ch;
		logic [BUCKET_INDEX_W-1:0] idx;
		pick = $urandom_range(0, 199);
		ch = BASE_CHAR_W'($urandom_range(0, 255));
		idx = BUCKET_INDEX_W'($urandom_range(0, 4095));
		if (pick < 2)
			op = OP_START;
		else if (pick < 8)
			op = OP_NONE;
		else if (pick < 60)
			op = OP_READ;
		else
			op = OP_BASE;
		if (op == OP_BASE && $urandom_range(0, 7) != 0) begin
			case ($urandom_range(0, 3))
				0: ch = CHAR_A;
				1: ch = CHAR_C;
				2: ch = CHAR_G;
				default: ch = CHAR_T;
			endcase
		end
		// aim most reads at buckets that can actually fill
		if (op == OP_READ && $urandom_range(0, 9) < 7)
			idx = idx & BUCKET_INDEX_W'(span_mask);
		send_word(op, ch, idx);
	endtask

	// result side: ready runs broken by stalls
	initial begin
		int run;
		int stall;
		read_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			read_bus.ready <= 1'b1;
			repeat (run) @(negedge clk);
			stall = gap_len();
			if (stall > 0) begin
				read_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("kmer_minhash_sketch_core: mismatch");
		$finish;
	end

	initial begin
		logic [CFG_DATA_W-1:0] klen;
		logic [CFG_DATA_W-1:0] bits;
		int target;
		arst_n = 1'b0;
		word_bus.valid = 1'b0;
		word_bus.operation = OP_START;
		word_bus.base_char = '0;
		word_bus.bucket_index = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_KMER_LENGTH;
		cfg_bus.data = '0;
		calm_left = 0;
		span_mask = (1 << BUCKET_BITS_RST) - 1;
		n_useful = 0;
		n_bases = 0;
		n_reads = 0;
		n_starts = 0;
		n_ignored = 0;
		n_settings = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// empty store after reset, both index extremes, ignored op with all bits set
		send_word(OP_READ, 8'h00, 12'h000);
		send_word(OP_READ, 8'hFF, 12'hFFF);
		send_word(OP_NONE, 8'hFF, 12'hFFF);
		// short k-mers, bucket width left at its reset value
		program_regs(5'd3, 5'd0, 1'b0, 1'b0);
		send_word(OP_BASE, CHAR_A, 12'h000);
		send_word(OP_BASE, CHAR_C, 12'hFFF);
		send_word(OP_BASE, CHAR_G, 12'h000);
		send_word(OP_BASE, CHAR_T, 12'h000);
		send_word(OP_BASE, 8'hFF, 12'h000);
		send_word(OP_BASE, 8'h00, 12'h000);
		send_word(OP_READ, 8'h00, 12'h3FF);
		// two buckets, k-mer registers carried over
		program_regs(5'd3, 5'd1, 1'b1, 1'b0);
		send_word(OP_BASE, 8'h61, 12'h000);
		send_word(OP_BASE, CHAR_C, 12'h000);
		send_word(OP_BASE, CHAR_C, 12'h000);
		send_word(OP_READ, 8'h00, 12'h000);
		send_word(OP_READ, 8'h00, 12'h001);
		send_word(OP_READ, 8'h00, 12'h801);
		send_word(OP_START, 8'hFF, 12'hFFF);
		send_word(OP_READ, 8'h00, 12'h000);
		send_word(OP_READ, 8'h00, 12'h001);
		// palindrome-free triple: GGG against its complement CCC
		send_word(OP_BASE, CHAR_G, 12'h000);
		send_word(OP_BASE, CHAR_G, 12'h000);
		send_word(OP_BASE, CHAR_G, 12'h000);
		send_word(OP_READ, 8'h00, 12'h000);
		send_word(OP_READ, 8'h00, 12'h001);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin klen = 5'd31; bits = 5'd12; end
				1: begin klen = 5'd1;  bits = 5'd1;  end
				2: begin klen = 5'd0;  bits = 5'd0;  end
				3: begin klen = 5'd7;  bits = 5'd4;  end
				4: begin klen = 5'd31; bits = 5'd15; end
				5: begin
					klen = CFG_DATA_W'($urandom_range(0, 31));
					bits = CFG_DATA_W'($urandom_range(0, 31));
				end
				6: begin klen = 5'd12; bits = 5'd20; end
				7: begin klen = 5'd2;  bits = 5'd3;  end
				default: begin klen = 5'd31; bits = 5'd10; end
			endcase
			// odd phases keep the running sequence across the register change
			program_regs(klen, bits, 1'b1, p == 5);
			if (p % 2 == 0)
				send_word(OP_START, BASE_CHAR_W'($urandom_range(0, 255)),
					BUCKET_INDEX_W'($urandom_range(0, 4095)));
			target = n_useful + WORDS_PER_PHASE;
			while (n_useful < target)
				random_word();
		end

		word_bus.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d words: %0d bases, %0d bucket reads, %0d starts, %0d ignored",
			n_useful + n_ignored, n_bases, n_reads, n_starts, n_ignored);
		$display("covered %0d register settings incl. zero and over-range widths", n_settings);
		if (errors == 0)
			$display("kmer_minhash_sketch_core: match");
		else
			$display("kmer_minhash_sketch_core: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/kms_pkg.sv
hw/rtl/kms_cfg_if.sv
hw/rtl/kms_in_if.sv
hw/rtl/kms_out_if.sv
hw/rtl/kms_ctrl.sv
hw/rtl/kms_datapath.sv
hw/rtl/kmer_minhash_sketch_core.sv
tb/kms_sketch_checker.sv
tb/kmer_minhash_sketch_core_tb.sv
